// ===== design/svc_pkg.sv =====
package svc_pkg;

  localparam int unsigned POS_W    = 8;
  localparam int unsigned VAL_W    = 10;
  localparam int unsigned PULSE_W  = 14;
  localparam int unsigned LOAD_W   = 16;
  localparam int unsigned PROD_W   = POS_W + LOAD_W;
  localparam int unsigned RECIP_W  = 25;
  localparam int unsigned DIV_SH   = 34;

  localparam logic [POS_W-1:0]   POS_MIN      = 8'd26;
  localparam logic [POS_W-1:0]   POS_MAX      = 8'd141;
  localparam logic [POS_W-1:0]   HPOS_RESET   = 8'd75;
  localparam logic [POS_W-1:0]   VPOS_RESET   = 8'd50;
  localparam logic [VAL_W-1:0]   TARGET_RESET = 10'd83;
  localparam logic [LOAD_W-1:0]  LOAD_RESET   = 16'd11362;

  localparam logic [7:0] START_CHAR = 8'h52;
  localparam logic [7:0] END_CHAR   = 8'h78;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  // ceil(2^34 / 1000): exact floor(x/1000) for any 24-bit x
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd17179870;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] pitch;
    logic [VAL_W-1:0] roll;
    logic [VAL_W-1:0] yaw;
  } frame_info_t;

endpackage

// ===== design/servo_command_slew_controller_unit.sv =====
// An accepted transaction reaches out_* through the s1, s2 and out registers.
// Throughput: one transaction per cycle while out_stall does not back up the pipeline;
// the reciprocal multiply that scales each position into a pulse width sets the three-stage depth.
// Reset (rst_n low, synchronous): parser idle, digit slots zero, positions
// 75/50, target 83, period_load 11362, pipeline empty.
module servo_command_slew_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_button_up,
  input  logic        in_button_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_pulse_out0,
  output logic [13:0] out_pulse_out1,
  output logic        out_frame_done,
  output logic [9:0]  out_pitch_value,
  output logic [9:0]  out_roll_value,
  output logic [9:0]  out_yaw_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned QFULL_W = svc_pkg::PROD_W + svc_pkg::RECIP_W;

  logic [svc_pkg::LOAD_W-1:0] period_load_r;

  logic                       in_frame_r, in_frame_nxt;
  logic [1:0]                 field_r, field_nxt;
  logic [1:0]                 dpos_r, dpos_nxt;
  svc_pkg::digit_t            slots_r [9];
  svc_pkg::digit_t            slots_nxt [9];
  logic [svc_pkg::POS_W-1:0]  hpos_r, hpos_nxt;
  logic [svc_pkg::POS_W-1:0]  vpos_r, vpos_nxt;
  logic [svc_pkg::VAL_W-1:0]  target_r, target_nxt;

  logic                       s1_valid_r, s2_valid_r, out_valid_r;
  logic                       s1_en, s2_en, out_en, accept;
  logic [svc_pkg::POS_W-1:0]  s1_vpos_r, s1_hpos_r;
  svc_pkg::frame_info_t       s1_info_r, s2_info_r, out_info_r, info_nxt;
  logic [svc_pkg::PROD_W-1:0] s2_prod0_r, s2_prod1_r;
  logic [svc_pkg::PULSE_W-1:0] out_pulse0_r, out_pulse1_r;

  logic                       is_digit;
  logic [3:0]                 slot_idx;
  logic [svc_pkg::VAL_W-1:0]  fval [3];
  logic [QFULL_W-1:0]         q0_full, q1_full;

  assign out_en   = !out_valid_r || !out_stall;
  assign s2_en    = !s2_valid_r || out_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;
  assign accept   = in_valid && s1_en;

  assign cfg_ready = 1'b1;

  assign is_digit = (in_rx_byte >= svc_pkg::DIGIT_ZERO) && (in_rx_byte <= svc_pkg::DIGIT_NINE);
  assign slot_idx = 4'((field_r - 2'd1) * 3) + 4'(dpos_r);

  always_comb begin
    for (int f = 0; f < 3; f++) begin
      fval[f] = 10'(slots_r[f*3]) * 10'd100 + 10'(slots_r[f*3+1]) * 10'd10
              + 10'(slots_r[f*3+2]);
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    field_nxt    = field_r;
    dpos_nxt     = dpos_r;
    slots_nxt    = slots_r;
    hpos_nxt     = hpos_r;
    vpos_nxt     = vpos_r;
    target_nxt   = target_r;
    info_nxt     = '0;
    if (!in_action) begin
      if (!in_frame_r) begin
        if (in_rx_byte == svc_pkg::START_CHAR) begin
          in_frame_nxt = 1'b1;
          field_nxt    = 2'd0;
          dpos_nxt     = 2'd0;
          for (int i = 0; i < 9; i++) slots_nxt[i] = '0;
        end
      end else if (in_rx_byte == svc_pkg::END_CHAR) begin
        info_nxt.done  = 1'b1;
        info_nxt.pitch = fval[0];
        info_nxt.roll  = fval[1];
        info_nxt.yaw   = fval[2];
        target_nxt     = fval[0];
        in_frame_nxt   = 1'b0;
      end else if (in_rx_byte == svc_pkg::SPACE_CHAR) begin
        if (field_r != 2'd3) field_nxt = field_r + 2'd1;
        dpos_nxt = 2'd0;
      end else if (is_digit) begin
        if (field_r != 2'd0 && dpos_r != 2'd3) begin
          for (int i = 0; i < 9; i++) begin
            if (slot_idx == 4'(i)) slots_nxt[i] = in_rx_byte[3:0];
          end
          dpos_nxt = dpos_r + 2'd1;
        end
      end
    end else begin
      if (10'(hpos_r) < target_r) begin
        hpos_nxt = (hpos_r >= svc_pkg::POS_MAX) ? svc_pkg::POS_MAX : hpos_r + 8'd1;
        if (hpos_nxt < svc_pkg::POS_MIN) hpos_nxt = svc_pkg::POS_MIN;
      end else if (10'(hpos_r) > target_r) begin
        hpos_nxt = (hpos_r <= svc_pkg::POS_MIN) ? svc_pkg::POS_MIN : hpos_r - 8'd1;
        if (hpos_nxt > svc_pkg::POS_MAX) hpos_nxt = svc_pkg::POS_MAX;
      end
      if (in_button_up) begin
        vpos_nxt = (vpos_r >= svc_pkg::POS_MAX) ? svc_pkg::POS_MAX : vpos_r + 8'd1;
        if (vpos_nxt < svc_pkg::POS_MIN) vpos_nxt = svc_pkg::POS_MIN;
      end else if (in_button_down) begin
        vpos_nxt = (vpos_r <= svc_pkg::POS_MIN) ? svc_pkg::POS_MIN : vpos_r - 8'd1;
        if (vpos_nxt > svc_pkg::POS_MAX) vpos_nxt = svc_pkg::POS_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_load_r <= svc_pkg::LOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period_load_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      field_r    <= 2'd0;
      dpos_r     <= 2'd0;
      for (int i = 0; i < 9; i++) slots_r[i] <= '0;
      hpos_r     <= svc_pkg::HPOS_RESET;
      vpos_r     <= svc_pkg::VPOS_RESET;
      target_r   <= svc_pkg::TARGET_RESET;
    end else if (accept) begin
      in_frame_r <= in_frame_nxt;
      field_r    <= field_nxt;
      dpos_r     <= dpos_nxt;
      slots_r    <= slots_nxt;
      hpos_r     <= hpos_nxt;
      vpos_r     <= vpos_nxt;
      target_r   <= target_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_r  <= in_valid;
      if (s2_en)  s2_valid_r  <= s1_valid_r;
      if (out_en) out_valid_r <= s2_valid_r;
    end
  end

  assign q0_full = QFULL_W'(s2_prod0_r) * QFULL_W'(svc_pkg::DIV_RECIP);
  assign q1_full = QFULL_W'(s2_prod1_r) * QFULL_W'(svc_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vpos_r <= vpos_nxt;
      s1_hpos_r <= hpos_nxt;
      s1_info_r <= info_nxt;
    end
    if (s2_en && s1_valid_r) begin
      s2_prod0_r <= svc_pkg::PROD_W'(s1_vpos_r) * svc_pkg::PROD_W'(period_load_r);
      s2_prod1_r <= svc_pkg::PROD_W'(s1_hpos_r) * svc_pkg::PROD_W'(period_load_r);
      s2_info_r  <= s1_info_r;
    end
    if (out_en && s2_valid_r) begin
      out_pulse0_r <= q0_full[svc_pkg::DIV_SH +: svc_pkg::PULSE_W];
      out_pulse1_r <= q1_full[svc_pkg::DIV_SH +: svc_pkg::PULSE_W];
      out_info_r   <= s2_info_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pulse_out0  = out_pulse0_r;
  assign out_pulse_out1  = out_pulse1_r;
  assign out_frame_done  = out_info_r.done;
  assign out_pitch_value = out_info_r.pitch;
  assign out_roll_value  = out_info_r.roll;
  assign out_yaw_value   = out_info_r.yaw;

endmodule
